// ===== hdl/sst_pkg.sv =====
// Shared codes and field widths for the small set table.
package sst_pkg;

   localparam int ELEM_W    = 32;
   localparam int MODE_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int POS_W     = 4;
   localparam int LIVE_W    = 5;

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [ELEM_W-1:0]   elem_type;

   localparam mode_type MODE_ADD    = 2'd0;
   localparam mode_type MODE_REMOVE = 2'd1;
   localparam mode_type MODE_SEARCH = 2'd2;

   localparam status_type STATUS_DONE    = 2'd0;
   localparam status_type STATUS_PRESENT = 2'd1;
   localparam status_type STATUS_ABSENT  = 2'd2;
   localparam status_type STATUS_FULL    = 2'd3;

endpackage

// ===== hdl/sst_mem.sv =====
// Entry store: one write port, one read port with registered read data.
module sst_mem
   import sst_pkg::*;
#(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  elem_type          wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output elem_type          rd_data
);

   elem_type mem_ff [DEPTH];
   elem_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/small_set_table.sv =====
// small_set_table: set of distinct 32-bit values with add, remove and search.
//
// Usage: requests arrive on req_ (req_mode, req_element) with valid/ready;
// each request gives exactly one result on rsp_ (rsp_status, rsp_position,
// rsp_live_count). Mode 0 adds, 1 removes (the last live entry is moved into
// the freed slot), 2 searches; mode 3 behaves as search.
// Scan: a request scans the stored entries one per cycle through the
// single read port of the entry memory, until the value is found or the
// last live entry has been checked. A remove with a hit then fetches the
// last live entry and writes it into the freed slot in a move state; the
// result is then handed to the output register from a done state. One
// item is worked on at a time.
// Reset: the live count is cleared, so the set is empty; memory contents are
// not touched and are only read below the live count.
// Stall: the result waits in the output register until taken. The next
// request can be accepted meanwhile; its result waits in the block until
// the output register frees up.
module small_set_table
   import sst_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [MODE_W-1:0]      req_mode,
   input  logic signed [ELEM_W-1:0] req_element,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [POS_W-1:0]       rsp_position,
   output logic [LIVE_W-1:0]      rsp_live_count
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_MOVE = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]        state_ff, state_in;
   mode_type          mode_ff, mode_in;
   elem_type          elem_ff, elem_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              chk_valid_ff, chk_valid_in;
   logic [ADDR_W-1:0] chk_idx_ff, chk_idx_in;
   logic [ADDR_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   status_type        res_status_ff, res_status_in;
   logic [POS_W-1:0]  res_pos_ff, res_pos_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [LIVE_W-1:0] rsp_live_ff, rsp_live_in;

   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   elem_type          mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   elem_type          mem_rd_data;

   logic              issue_ok;
   logic              match;
   logic              last_chk;
   logic              miss;
   logic              full;
   logic [CNT_W-1:0]  count_dec;

   sst_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign count_dec = count_ff - CNT_W'(1);
   assign issue_ok  = (idx_ff < count_ff);
   assign match     = chk_valid_ff && (mem_rd_data == elem_ff);
   assign last_chk  = chk_valid_ff && (CNT_W'(chk_idx_ff) == count_dec);
   assign miss      = !match && ((count_ff == '0) || last_chk);
   assign full      = (count_ff == CNT_W'(DEPTH));

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      elem_in       = elem_ff;
      idx_in        = idx_ff;
      chk_valid_in  = chk_valid_ff;
      chk_idx_in    = chk_idx_ff;
      slot_in       = slot_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_live_in   = rsp_live_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = ADDR_W'(count_ff);
      mem_wr_data   = elem_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = ADDR_W'(idx_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in      = req_mode;
               elem_in      = elem_type'(req_element);
               idx_in       = '0;
               chk_valid_in = 1'b0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (match || miss) begin
               chk_valid_in = 1'b0;
               state_in     = ST_DONE;
               res_pos_in   = '0;
               if (mode_ff == MODE_ADD) begin
                  if (match) begin
                     res_status_in = STATUS_PRESENT;
                     res_pos_in    = POS_W'(chk_idx_ff);
                  end else if (full) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     mem_wr_en     = 1'b1;
                     res_status_in = STATUS_DONE;
                     res_pos_in    = POS_W'(count_ff);
                     count_in      = count_ff + CNT_W'(1);
                  end
               end else if (mode_ff == MODE_REMOVE) begin
                  if (match) begin
                     // fetch the last live entry to fill the freed slot
                     mem_rd_en     = 1'b1;
                     mem_rd_addr   = ADDR_W'(count_dec);
                     slot_in       = chk_idx_ff;
                     res_status_in = STATUS_DONE;
                     res_pos_in    = POS_W'(chk_idx_ff);
                     state_in      = ST_MOVE;
                  end else begin
                     res_status_in = STATUS_ABSENT;
                  end
               end else begin
                  if (match) begin
                     res_status_in = STATUS_DONE;
                     res_pos_in    = POS_W'(chk_idx_ff);
                  end else begin
                     res_status_in = STATUS_ABSENT;
                  end
               end
            end else begin
               mem_rd_en    = issue_ok;
               chk_valid_in = issue_ok;
               chk_idx_in   = ADDR_W'(idx_ff);
               if (issue_ok) begin
                  idx_in = idx_ff + CNT_W'(1);
               end
            end
         end
         ST_MOVE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = slot_ff;
            mem_wr_data = mem_rd_data;
            count_in    = count_dec;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pos_in    = res_pos_ff;
               rsp_live_in   = LIVE_W'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      elem_ff       <= elem_in;
      idx_ff        <= idx_in;
      chk_idx_ff    <= chk_idx_in;
      slot_ff       <= slot_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_live_ff   <= rsp_live_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_position   = rsp_pos_ff;
   assign rsp_live_count = rsp_live_ff;

endmodule
